FILE: rtl/tlik_pkg.sv
// tlik_pkg: shared widths, constants, cell state types and the arctangent table
// for the two-link leg inverse kinematics solver. No dependencies.
package tlik_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TAB_LEN       = 24;
  localparam int CORDIC_CELLS  = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  localparam int LEN_W     = 15;
  localparam int COORD_W   = 16;
  localparam int ANG_W     = 16;
  localparam int DIFF_W    = 17;
  localparam int RAD_W     = 34;
  localparam int ROOT_W    = 17;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int NUM_W     = 34;
  localparam int DEN_W     = 32;
  localparam int REM_W     = 33;
  localparam int QUO_W     = 15;
  localparam int CSQ_W     = 29;
  localparam int CW        = 36;
  localparam int ZW        = 20;
  localparam int ACC_W     = 18;
  localparam int BIT_IDX_W = 5;
  localparam int SCALE_SH  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FEMUR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIBIA = 1'd1;

  localparam logic [LEN_W-1:0]        LEN_RESET = 15'd1600;
  localparam logic signed [ZW-1:0]    HALF_PI_Z = 20'sd102944;
  localparam logic signed [ACC_W-1:0] PI_Q12    = 18'sd12868;
  localparam logic signed [ACC_W-1:0] ANGLE_MAX = 18'sd25736;
  localparam logic signed [ANG_W-1:0] ANGLE_LIM = 16'sd25736;
  localparam logic [QUO_W-1:0]        ONE_MAG   = 15'd16384;
  localparam logic [CSQ_W-1:0]        ONE_SQ    = 29'h1000_0000;

  typedef logic signed [CW-1:0] cx_t;
  typedef logic signed [ZW-1:0] z_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_st_t;

  typedef struct packed {
    cx_t x;
    cx_t y;
    z_t  z;
  } cvec_t;

  localparam z_t ATAN_TAB [0:TAB_LEN-1] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
  };

  // atan(2^-i) in units of 2^-16 rad, zero past the end of the table
  function automatic z_t atan_entry(input logic [BIT_IDX_W-1:0] idx);
    z_t v;
    v = '0;
    if (idx < BIT_IDX_W'(TAB_LEN)) begin
      v = ATAN_TAB[idx];
    end
    return v;
  endfunction

endpackage

FILE: rtl/two_link_leg_ik_solver_core.sv
// two_link_leg_ik_solver_core: planar two-link leg inverse kinematics, top level.
// Depends on tlik_pkg, tlik_sqrt_cell, tlik_div_cell and tlik_cordic_cell.
//
//   channel | signals                                  | dir | handshake
//   in      | in_target_x/y, in_joint_x/y              | in  | in_valid / in_ready
//   out     | out_upper_angle, out_lower_angle         | out | out_valid / out_ready
//   cfg     | cfg_wr_en, cfg_index, cfg_data           | in  | write enable, no wait
//
// one word accepted per cycle while in_ready is high; 65 + CORDIC_STAGES register stages,
// among them the distance root cells, the cosine divider cells, the sine root cells
// and the cordic cells
// reset clears every stage valid bit and loads both lengths with 1600
// a word held in the output register with out_ready low parks the next one in a
// skid register; in_ready falls only while that skid register is full, and then
// the whole chain holds
module two_link_leg_ik_solver_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tlik_pkg::COORD_W-1:0]   in_target_x,
  input  logic signed [tlik_pkg::COORD_W-1:0]   in_target_y,
  input  logic signed [tlik_pkg::COORD_W-1:0]   in_joint_x,
  input  logic signed [tlik_pkg::COORD_W-1:0]   in_joint_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tlik_pkg::ANG_W-1:0]     out_upper_angle,
  output logic signed [tlik_pkg::ANG_W-1:0]     out_lower_angle,
  input  logic                                  cfg_wr_en,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tlik_pkg::LEN_W-1:0]            cfg_data
);

  localparam int NSQ = tlik_pkg::SQRT_CELLS;
  localparam int NQ  = tlik_pkg::QUO_W;
  localparam int NC  = tlik_pkg::CORDIC_CELLS;

  typedef struct packed {
    logic signed [tlik_pkg::DIFF_W-1:0] dx;
    logic signed [tlik_pkg::DIFF_W-1:0] dy;
  } off_t;

  typedef struct packed {
    off_t       off;
    logic [1:0] neg;
    logic [1:0] ovf;
  } div_side_t;

  typedef struct packed {
    off_t                              off;
    logic signed [tlik_pkg::ANG_W-1:0] c1;
    logic signed [tlik_pkg::ANG_W-1:0] c0;
  } root_side_t;

  // ---------------- configuration ----------------
  logic [tlik_pkg::LEN_W-1:0] femur_r, tibia_r;
  logic [tlik_pkg::LEN_W-1:0] f_eff, t_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      femur_r <= tlik_pkg::LEN_RESET;
      tibia_r <= tlik_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tlik_pkg::REG_FEMUR: femur_r <= cfg_data;
        tlik_pkg::REG_TIBIA: tibia_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero length reads as one
  assign f_eff = (femur_r == '0) ? tlik_pkg::LEN_W'(1) : femur_r;
  assign t_eff = (tibia_r == '0) ? tlik_pkg::LEN_W'(1) : tibia_r;

  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_ready = en;

  // ---------------- offset and its squares ----------------
  logic s0_v_r, s1_v_r, s2_v_r;
  off_t s0_off_r, s1_off_r, s2_off_r;
  logic signed [tlik_pkg::RAD_W-1:0] dxx_full, dyy_full;
  logic [tlik_pkg::RAD_W-1:0] dxx_r, dyy_r, s2_sum_r;

  assign dxx_full = s0_off_r.dx * s0_off_r.dx;
  assign dyy_full = s0_off_r.dy * s0_off_r.dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_off_r.dx <= tlik_pkg::DIFF_W'(in_target_x) - tlik_pkg::DIFF_W'(in_joint_x);
      s0_off_r.dy <= tlik_pkg::DIFF_W'(in_target_y) - tlik_pkg::DIFF_W'(in_joint_y);
      dxx_r       <= dxx_full;
      dyy_r       <= dyy_full;
      s1_off_r    <= s0_off_r;
      s2_sum_r    <= dxx_r + dyy_r;
      s2_off_r    <= s1_off_r;
    end
  end

  // ---------------- distance root cells ----------------
  tlik_pkg::sqrt_st_t sa_d [0:NSQ-1];
  tlik_pkg::sqrt_st_t sa_q [0:NSQ-1];
  logic [NSQ-1:0] sa_v_r;
  off_t sa_off_r [0:NSQ-1];

  assign sa_d[0] = '{rem: s2_sum_r, root: '0};

  for (genvar j = 0; j < NSQ; j++) begin : g_sa
    tlik_sqrt_cell u_cell (
      .clk     (clk),
      .en      (en),
      .bit_idx (tlik_pkg::BIT_IDX_W'(NSQ - 1 - j)),
      .st_in   (sa_d[j]),
      .st_out  (sa_q[j])
    );
    if (j > 0) begin : g_link
      assign sa_d[j] = sa_q[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= '0;
    end else if (en) begin
      sa_v_r <= {sa_v_r[NSQ-2:0], s2_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_off_r[0] <= s2_off_r;
      for (int j = 1; j < NSQ; j++) begin
        sa_off_r[j] <= sa_off_r[j-1];
      end
    end
  end

  // ---------------- clamp, products, numerators ----------------
  logic [tlik_pkg::LEN_W:0]   reach_hi;
  logic [tlik_pkg::LEN_W-1:0] reach_lo;
  logic [tlik_pkg::ROOT_W-1:0] root_a;
  logic [tlik_pkg::LEN_W:0]   d_nxt, d_r;
  logic s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  off_t s3_off_r, s4_off_r, s5_off_r, s6_off_r, s7_off_r;

  always_comb begin
    root_a   = sa_q[NSQ-1].root;
    reach_hi = {1'b0, f_eff} + {1'b0, t_eff};
    reach_lo = (f_eff > t_eff) ? f_eff - t_eff : t_eff - f_eff;
    if (root_a > {1'b0, reach_hi}) begin
      d_nxt = reach_hi;
    end else if (root_a < tlik_pkg::ROOT_W'(reach_lo)) begin
      d_nxt = {1'b0, reach_lo};
    end else begin
      d_nxt = root_a[tlik_pkg::LEN_W:0];
    end
    // zero distance becomes one lsb
    if (d_nxt == '0) begin
      d_nxt = (tlik_pkg::LEN_W+1)'(1);
    end
  end

  logic [2*tlik_pkg::LEN_W-1:0]     ff_r, tt_r, ft_r;
  logic [2*tlik_pkg::LEN_W+1:0]     dd_r;
  logic [2*tlik_pkg::LEN_W:0]       fd_r;
  logic signed [tlik_pkg::NUM_W-1:0] num_r [0:1];
  logic [tlik_pkg::DEN_W-1:0]       den5_r [0:1];
  logic [tlik_pkg::DEN_W-1:0]       den6_r [0:1];
  logic [tlik_pkg::NUM_W-1:0]       mag_r [0:1];
  logic [1:0]                       neg6_r, neg7_r, ovf7_r;
  tlik_pkg::div_st_t                div0_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= sa_v_r[NSQ-1];
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= d_nxt;
      s3_off_r <= sa_off_r[NSQ-1];

      ff_r <= (2*tlik_pkg::LEN_W)'(f_eff) * (2*tlik_pkg::LEN_W)'(f_eff);
      tt_r <= (2*tlik_pkg::LEN_W)'(t_eff) * (2*tlik_pkg::LEN_W)'(t_eff);
      ft_r <= (2*tlik_pkg::LEN_W)'(f_eff) * (2*tlik_pkg::LEN_W)'(t_eff);
      dd_r <= (2*tlik_pkg::LEN_W+2)'(d_r) * (2*tlik_pkg::LEN_W+2)'(d_r);
      fd_r <= (2*tlik_pkg::LEN_W+1)'(f_eff) * (2*tlik_pkg::LEN_W+1)'(d_r);
      s4_off_r <= s3_off_r;

      // lane 0 feeds the femur angle, lane 1 the knee angle
      num_r[0]  <= $signed({4'b0, ff_r}) + $signed({2'b0, dd_r}) - $signed({4'b0, tt_r});
      num_r[1]  <= $signed({4'b0, ff_r}) + $signed({4'b0, tt_r}) - $signed({2'b0, dd_r});
      den5_r[0] <= {fd_r, 1'b0};
      den5_r[1] <= {1'b0, ft_r, 1'b0};
      s5_off_r  <= s4_off_r;

      for (int l = 0; l < 2; l++) begin
        mag_r[l]  <= num_r[l][tlik_pkg::NUM_W-1] ? tlik_pkg::NUM_W'(-num_r[l])
                                                 : tlik_pkg::NUM_W'(num_r[l]);
        neg6_r[l] <= num_r[l][tlik_pkg::NUM_W-1];
        den6_r[l] <= den5_r[l];
      end
      s6_off_r <= s5_off_r;

      // quotient of 2 or more saturates anyway
      for (int l = 0; l < 2; l++) begin
        ovf7_r[l]      <= mag_r[l] >= {1'b0, den6_r[l], 1'b0};
        neg7_r[l]      <= neg6_r[l];
        div0_r[l].den  <= den6_r[l];
        div0_r[l].rem  <= mag_r[l][tlik_pkg::REM_W-1:0];
        div0_r[l].quo  <= '0;
      end
      s7_off_r <= s6_off_r;
    end
  end

  // ---------------- cosine divider cells ----------------
  tlik_pkg::div_st_t db_d [0:1][0:NQ-1];
  tlik_pkg::div_st_t db_q [0:1][0:NQ-1];
  logic [NQ-1:0] db_v_r;
  div_side_t db_side_r [0:NQ-1];

  for (genvar l = 0; l < 2; l++) begin : g_db_lane
    assign db_d[l][0] = div0_r[l];
    for (genvar j = 0; j < NQ; j++) begin : g_db
      tlik_div_cell u_cell (
        .clk    (clk),
        .en     (en),
        .st_in  (db_d[l][j]),
        .st_out (db_q[l][j])
      );
      if (j > 0) begin : g_link
        assign db_d[l][j] = db_q[l][j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_v_r <= '0;
    end else if (en) begin
      db_v_r <= {db_v_r[NQ-2:0], s7_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db_side_r[0] <= '{off: s7_off_r, neg: neg7_r, ovf: ovf7_r};
      for (int j = 1; j < NQ; j++) begin
        db_side_r[j] <= db_side_r[j-1];
      end
    end
  end

  // ---------------- cosine, sine radicand ----------------
  logic [tlik_pkg::QUO_W-1:0]          cmag [0:1];
  logic signed [tlik_pkg::ANG_W-1:0]   c8_r [0:1];
  logic signed [tlik_pkg::ANG_W-1:0]   c9_r [0:1];
  logic signed [tlik_pkg::ANG_W-1:0]   c10_r [0:1];
  logic signed [2*tlik_pkg::ANG_W-1:0] csq_full [0:1];
  logic [tlik_pkg::CSQ_W-1:0]          csq_r [0:1];
  tlik_pkg::sqrt_st_t                  sc0_r [0:1];
  logic s8_v_r, s9_v_r, s10_v_r;
  off_t s8_off_r, s9_off_r, s10_off_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (db_side_r[NQ-1].ovf[l] || db_q[l][NQ-1].quo > tlik_pkg::ONE_MAG) begin
        cmag[l] = tlik_pkg::ONE_MAG;
      end else begin
        cmag[l] = db_q[l][NQ-1].quo;
      end
      csq_full[l] = c8_r[l] * c8_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r  <= db_v_r[NQ-1];
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        c8_r[l]  <= db_side_r[NQ-1].neg[l] ? -$signed({1'b0, cmag[l]})
                                           : $signed({1'b0, cmag[l]});
        csq_r[l] <= csq_full[l][tlik_pkg::CSQ_W-1:0];
        c9_r[l]  <= c8_r[l];
        sc0_r[l].rem  <= tlik_pkg::RAD_W'(tlik_pkg::ONE_SQ - csq_r[l]);
        sc0_r[l].root <= '0;
        c10_r[l] <= c9_r[l];
      end
      s8_off_r  <= db_side_r[NQ-1].off;
      s9_off_r  <= s8_off_r;
      s10_off_r <= s9_off_r;
    end
  end

  // ---------------- sine root cells ----------------
  tlik_pkg::sqrt_st_t sc_d [0:1][0:NSQ-1];
  tlik_pkg::sqrt_st_t sc_q [0:1][0:NSQ-1];
  logic [NSQ-1:0] sc_v_r;
  root_side_t sc_side_r [0:NSQ-1];

  for (genvar l = 0; l < 2; l++) begin : g_sc_lane
    assign sc_d[l][0] = sc0_r[l];
    for (genvar j = 0; j < NSQ; j++) begin : g_sc
      tlik_sqrt_cell u_cell (
        .clk     (clk),
        .en      (en),
        .bit_idx (tlik_pkg::BIT_IDX_W'(NSQ - 1 - j)),
        .st_in   (sc_d[l][j]),
        .st_out  (sc_q[l][j])
      );
      if (j > 0) begin : g_link
        assign sc_d[l][j] = sc_q[l][j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= '0;
    end else if (en) begin
      sc_v_r <= {sc_v_r[NSQ-2:0], s10_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_side_r[0] <= '{off: s10_off_r, c1: c10_r[1], c0: c10_r[0]};
      for (int j = 1; j < NSQ; j++) begin
        sc_side_r[j] <= sc_side_r[j-1];
      end
    end
  end

  // ---------------- cordic set-up: base angle and the two arc-cosines ----------------
  tlik_pkg::cx_t   yin [0:2];
  tlik_pkg::cx_t   xin [0:2];
  tlik_pkg::cx_t   xsc, ysc;
  tlik_pkg::cvec_t pre_nxt [0:2];
  logic [2:0]      zero_nxt;
  tlik_pkg::cvec_t pre_r [0:2];
  logic [2:0]      zero11_r;
  logic            s11_v_r;

  always_comb begin
    yin[0] = tlik_pkg::CW'(sc_side_r[NSQ-1].off.dy);
    xin[0] = tlik_pkg::CW'(sc_side_r[NSQ-1].off.dx);
    yin[1] = tlik_pkg::CW'(sc_q[0][NSQ-1].root);
    xin[1] = tlik_pkg::CW'(sc_side_r[NSQ-1].c0);
    yin[2] = tlik_pkg::CW'(sc_q[1][NSQ-1].root);
    xin[2] = tlik_pkg::CW'(sc_side_r[NSQ-1].c1);
    for (int l = 0; l < 3; l++) begin
      zero_nxt[l] = (xin[l] == '0) && (yin[l] == '0);
      xsc = xin[l] <<< tlik_pkg::SCALE_SH;
      ysc = yin[l] <<< tlik_pkg::SCALE_SH;
      // left half-plane: turn by a quarter first
      if (xsc[tlik_pkg::CW-1]) begin
        if (!ysc[tlik_pkg::CW-1]) begin
          pre_nxt[l].x = ysc;
          pre_nxt[l].y = -xsc;
          pre_nxt[l].z = tlik_pkg::HALF_PI_Z;
        end else begin
          pre_nxt[l].x = -ysc;
          pre_nxt[l].y = xsc;
          pre_nxt[l].z = -tlik_pkg::HALF_PI_Z;
        end
      end else begin
        pre_nxt[l].x = xsc;
        pre_nxt[l].y = ysc;
        pre_nxt[l].z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r <= 1'b0;
    end else if (en) begin
      s11_v_r <= sc_v_r[NSQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pre_r[l] <= pre_nxt[l];
      end
      zero11_r <= zero_nxt;
    end
  end

  // ---------------- cordic cells ----------------
  tlik_pkg::cvec_t cd_d [0:2][0:NC-1];
  tlik_pkg::cvec_t cd_q [0:2][0:NC-1];
  logic [NC-1:0] cd_v_r;
  logic [2:0]    cd_zero_r [0:NC-1];

  for (genvar l = 0; l < 3; l++) begin : g_cd_lane
    assign cd_d[l][0] = pre_r[l];
    for (genvar j = 0; j < NC; j++) begin : g_cd
      tlik_cordic_cell u_cell (
        .clk       (clk),
        .en        (en),
        .stage_idx (tlik_pkg::BIT_IDX_W'(j)),
        .vec_in    (cd_d[l][j]),
        .vec_out   (cd_q[l][j])
      );
      if (j > 0) begin : g_link
        assign cd_d[l][j] = cd_q[l][j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_v_r <= '0;
    end else if (en) begin
      cd_v_r <= {cd_v_r[NC-2:0], s11_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_zero_r[0] <= zero11_r;
      for (int j = 1; j < NC; j++) begin
        cd_zero_r[j] <= cd_zero_r[j-1];
      end
    end
  end

  // ---------------- angle rounding, law of cosines, saturation ----------------
  tlik_pkg::z_t                       zr [0:2];
  logic signed [tlik_pkg::ACC_W-1:0]  ang_nxt [0:2];
  logic signed [tlik_pkg::ACC_W-1:0]  ang_r [0:2];
  logic signed [tlik_pkg::ACC_W-1:0]  upper_r, lower_r;
  logic signed [tlik_pkg::ANG_W-1:0]  up_sat, lo_sat;
  logic signed [tlik_pkg::ANG_W-1:0]  last_up_r, last_lo_r;
  logic s12_v_r, s13_v_r, last_v_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      zr[l] = cd_q[l][NC-1].z + tlik_pkg::ZW'(8);
      ang_nxt[l] = cd_zero_r[NC-1][l] ? '0 : tlik_pkg::ACC_W'(zr[l] >>> 4);
    end
    if (upper_r > tlik_pkg::ANGLE_MAX) begin
      up_sat = tlik_pkg::ANGLE_LIM;
    end else if (upper_r < -tlik_pkg::ANGLE_MAX) begin
      up_sat = -tlik_pkg::ANGLE_LIM;
    end else begin
      up_sat = upper_r[tlik_pkg::ANG_W-1:0];
    end
    if (lower_r > tlik_pkg::ANGLE_MAX) begin
      lo_sat = tlik_pkg::ANGLE_LIM;
    end else if (lower_r < -tlik_pkg::ANGLE_MAX) begin
      lo_sat = -tlik_pkg::ANGLE_LIM;
    end else begin
      lo_sat = lower_r[tlik_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s12_v_r  <= 1'b0;
      s13_v_r  <= 1'b0;
      last_v_r <= 1'b0;
    end else if (en) begin
      s12_v_r  <= cd_v_r[NC-1];
      s13_v_r  <= s12_v_r;
      last_v_r <= s13_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        ang_r[l] <= ang_nxt[l];
      end
      upper_r   <= ang_r[0] - ang_r[1];
      lower_r   <= tlik_pkg::PI_Q12 + ang_r[0] - ang_r[1] - ang_r[2];
      last_up_r <= up_sat;
      last_lo_r <= lo_sat;
    end
  end

  // ---------------- output register and skid ----------------
  logic                              out_v_r, out_v_nxt, skid_v_nxt, out_free;
  logic signed [tlik_pkg::ANG_W-1:0] out_up_r, out_up_nxt, out_lo_r, out_lo_nxt;
  logic signed [tlik_pkg::ANG_W-1:0] skid_up_r, skid_up_nxt, skid_lo_r, skid_lo_nxt;

  always_comb begin
    out_free    = !out_v_r || out_ready;
    out_v_nxt   = out_v_r;
    out_up_nxt  = out_up_r;
    out_lo_nxt  = out_lo_r;
    skid_v_nxt  = skid_v_r;
    skid_up_nxt = skid_up_r;
    skid_lo_nxt = skid_lo_r;
    if (skid_v_r) begin
      if (out_free) begin
        out_v_nxt  = 1'b1;
        out_up_nxt = skid_up_r;
        out_lo_nxt = skid_lo_r;
        skid_v_nxt = 1'b0;
      end
    end else if (last_v_r) begin
      // chain moves this cycle, the last word must land somewhere
      if (out_free) begin
        out_v_nxt  = 1'b1;
        out_up_nxt = last_up_r;
        out_lo_nxt = last_lo_r;
      end else begin
        skid_v_nxt  = 1'b1;
        skid_up_nxt = last_up_r;
        skid_lo_nxt = last_lo_r;
      end
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_up_r  <= out_up_nxt;
    out_lo_r  <= out_lo_nxt;
    skid_up_r <= skid_up_nxt;
    skid_lo_r <= skid_lo_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_upper_angle = out_up_r;
  assign out_lower_angle = out_lo_r;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while the output register is empty");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(last_v_r))
    else $error("last stage moved while the skid register was full");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid filled without an output stall");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_up_r <= tlik_pkg::ANGLE_LIM && out_up_r >= -tlik_pkg::ANGLE_LIM &&
                 out_lo_r <= tlik_pkg::ANGLE_LIM && out_lo_r >= -tlik_pkg::ANGLE_LIM))
    else $error("output angle outside the saturation band");

endmodule

FILE: rtl/tlik_sqrt_cell.sv
// tlik_sqrt_cell: one root bit of a digit-by-digit integer square root.
// Depends on tlik_pkg.
module tlik_sqrt_cell (
  input  logic                               clk,
  input  logic                               en,
  input  logic [tlik_pkg::BIT_IDX_W-1:0]     bit_idx,
  input  tlik_pkg::sqrt_st_t                 st_in,
  output tlik_pkg::sqrt_st_t                 st_out
);

  tlik_pkg::sqrt_st_t          st_nxt;
  tlik_pkg::sqrt_st_t          st_r;
  logic [tlik_pkg::RAD_W+1:0]  term;

  // (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
  always_comb begin
    term = ((tlik_pkg::RAD_W+2)'(st_in.root) << (bit_idx + 1))
         + ((tlik_pkg::RAD_W+2)'(1) << (2 * bit_idx));
    st_nxt = st_in;
    if ({2'b00, st_in.rem} >= term) begin
      st_nxt.rem  = st_in.rem - term[tlik_pkg::RAD_W-1:0];
      st_nxt.root = st_in.root | (tlik_pkg::ROOT_W'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

FILE: rtl/tlik_div_cell.sv
// tlik_div_cell: one quotient bit of a restoring divider, remainder kept below
// twice the divisor. Depends on tlik_pkg.
module tlik_div_cell (
  input  logic              clk,
  input  logic              en,
  input  tlik_pkg::div_st_t st_in,
  output tlik_pkg::div_st_t st_out
);

  tlik_pkg::div_st_t          st_nxt;
  tlik_pkg::div_st_t          st_r;
  logic                       ge;
  logic [tlik_pkg::REM_W-1:0] diff;

  always_comb begin
    ge   = st_in.rem >= {1'b0, st_in.den};
    diff = st_in.rem - {1'b0, st_in.den};
    st_nxt.den = st_in.den;
    st_nxt.rem = ge ? {diff[tlik_pkg::REM_W-2:0], 1'b0}
                    : {st_in.rem[tlik_pkg::REM_W-2:0], 1'b0};
    st_nxt.quo = {st_in.quo[tlik_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

FILE: rtl/tlik_cordic_cell.sv
// tlik_cordic_cell: one vectoring micro-rotation of the arctangent CORDIC.
// Depends on tlik_pkg (vector type and arctangent table).
module tlik_cordic_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tlik_pkg::BIT_IDX_W-1:0] stage_idx,
  input  tlik_pkg::cvec_t                vec_in,
  output tlik_pkg::cvec_t                vec_out
);

  tlik_pkg::cvec_t vec_nxt;
  tlik_pkg::cvec_t vec_r;
  tlik_pkg::cx_t   xi, yi, xs, ys;
  tlik_pkg::z_t    zi, step;

  always_comb begin
    xi   = vec_in.x;
    yi   = vec_in.y;
    zi   = vec_in.z;
    xs   = xi >>> stage_idx;
    ys   = yi >>> stage_idx;
    step = tlik_pkg::atan_entry(stage_idx);
    if (!yi[tlik_pkg::CW-1]) begin
      vec_nxt.x = xi + ys;
      vec_nxt.y = yi - xs;
      vec_nxt.z = zi + step;
    end else begin
      vec_nxt.x = xi - ys;
      vec_nxt.y = yi + xs;
      vec_nxt.z = zi - step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_out = vec_r;

endmodule

FILE: verif/two_link_leg_ik_solver_core_tb.sv
// two_link_leg_ik_solver_core_tb: random and directed check of the leg ik solver core
// against a bit-true prediction of the distance clamp, cosines and cordic angles.
// Depends on tlik_pkg and two_link_leg_ik_solver_core.
module two_link_leg_ik_solver_core_tb;

  localparam int N_RANDOM = 1050;
  localparam int LAT = 65 + tlik_pkg::CORDIC_STAGES;
  localparam longint HALF_PI_FX = 102944;
  localparam longint PI_FX = 12868;
  localparam longint ANG_LIM_FX = 25736;
  localparam longint ONE_FX = 16384;

  typedef struct packed {
    logic signed [tlik_pkg::COORD_W-1:0] tx;
    logic signed [tlik_pkg::COORD_W-1:0] ty;
    logic signed [tlik_pkg::COORD_W-1:0] jx;
    logic signed [tlik_pkg::COORD_W-1:0] jy;
  } target_t;

  typedef struct packed {
    logic signed [tlik_pkg::ANG_W-1:0] upper;
    logic signed [tlik_pkg::ANG_W-1:0] lower;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [tlik_pkg::COORD_W-1:0] in_target_x = '0, in_target_y = '0;
  logic signed [tlik_pkg::COORD_W-1:0] in_joint_x = '0, in_joint_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [tlik_pkg::ANG_W-1:0] out_upper_angle, out_lower_angle;
  logic cfg_wr_en = 1'b0;
  logic [tlik_pkg::CFG_IDX_W-1:0] cfg_index = tlik_pkg::REG_FEMUR;
  logic [tlik_pkg::LEN_W-1:0] cfg_data = '0;

  two_link_leg_ik_solver_core u_dut (.*);

  initial forever #6 clk = ~clk;

  longint femur_len = 1600, tibia_len = 1600;
  target_t pending_targets[$];
  angles_t expected_angles[$];
  int errors = 0;
  int n_popped = 0;
  int n_done = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_tx = 1'b0;
  int tx_gap = 0, rx_gap = 0;

  function automatic longint isqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_FX;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_FX;
      end
    end
    for (int i = 0; i < tlik_pkg::CORDIC_STAGES && i < tlik_pkg::TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(tlik_pkg::ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(tlik_pkg::ATAN_TAB[i]);
      end
    end
    return (z + 8) >>> 4;
  endfunction

  function automatic longint arc_cos(longint num, longint den);
    longint c;
    c = (num * ONE_FX) / den;
    if (c > ONE_FX) c = ONE_FX;
    if (c < -ONE_FX) c = -ONE_FX;
    return vector_angle(isqrt(ONE_FX * ONE_FX - c * c), c);
  endfunction

  function automatic logic signed [tlik_pkg::ANG_W-1:0] clip_angle(longint a);
    if (a > ANG_LIM_FX) a = ANG_LIM_FX;
    if (a < -ANG_LIM_FX) a = -ANG_LIM_FX;
    return a[tlik_pkg::ANG_W-1:0];
  endfunction

  function automatic angles_t solve_leg(target_t w);
    longint f, t, dx, dy, d, hi, lo, upper, lower;
    angles_t r;
    f = femur_len ? femur_len : 1;
    t = tibia_len ? tibia_len : 1;
    dx = longint'(w.tx) - longint'(w.jx);
    dy = longint'(w.ty) - longint'(w.jy);
    d = isqrt(dx * dx + dy * dy);
    hi = f + t;
    lo = f > t ? f - t : t - f;
    if (d > hi) d = hi;
    else if (d < lo) d = lo;
    if (d <= 0) d = 1;
    upper = vector_angle(dy, dx) - arc_cos(f * f + d * d - t * t, 2 * f * d);
    lower = PI_FX + upper - arc_cos(f * f + t * t - d * d, 2 * f * t);
    r.upper = clip_angle(upper);
    r.lower = clip_angle(lower);
    return r;
  endfunction

  function automatic void queue_target(target_t w);
    pending_targets = {pending_targets, w};
  endfunction

  // driver: the next word goes up only after the previous one was taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_angles = {expected_angles,
                           solve_leg({in_target_x, in_target_y, in_joint_x, in_joint_y})};
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (!tx_quiet && $urandom_range(0, 7) == 0) begin
          tx_gap <= $urandom_range(1, 15);
          in_valid <= 1'b0;
        end else if (!hold_tx && pending_targets.size() > 0) begin
          target_t w;
          w = pending_targets.pop_front();
          n_popped++;
          in_valid <= 1'b1;
          in_target_x <= w.tx;
          in_target_y <= w.ty;
          in_joint_x <= w.jx;
          in_joint_y <= w.jy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_done++;
        if (expected_angles.size() == 0) begin
          $error("unexpected word upper=%0d lower=%0d", out_upper_angle, out_lower_angle);
          errors++;
        end else begin
          angles_t e;
          e = expected_angles.pop_front();
          if (out_upper_angle !== e.upper) begin
            $error("upper_angle expected %0d actual %0d", e.upper, out_upper_angle);
            errors++;
          end
          if (out_lower_angle !== e.lower) begin
            $error("lower_angle expected %0d actual %0d", e.lower, out_lower_angle);
            errors++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(1, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [tlik_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return tlik_pkg::COORD_W'($urandom_range(0, 65535));
      default: return tlik_pkg::COORD_W'($urandom_range(0, 16383)) - 16'sd8192;
    endcase
  endfunction

  // mostly targets near the joint, each axis offset up to 5/4 of the full reach, rest anywhere
  function automatic target_t rand_target();
    target_t w;
    longint reach;
    w.jx = rand_coord();
    w.jy = rand_coord();
    if ($urandom_range(0, 3) != 0) begin
      reach = (femur_len + tibia_len) * 5 / 4 + 2;
      if (reach > 16000) reach = 16000;
      w.jx = $signed(tlik_pkg::COORD_W'($urandom_range(0, 32767))) >>> 1;
      w.jy = $signed(tlik_pkg::COORD_W'($urandom_range(0, 32767))) >>> 1;
      w.tx = w.jx + tlik_pkg::COORD_W'(longint'($urandom_range(0, 2 * reach)) - reach);
      w.ty = w.jy + tlik_pkg::COORD_W'(longint'($urandom_range(0, 2 * reach)) - reach);
    end else begin
      w.tx = rand_coord();
      w.ty = rand_coord();
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_targets.size() > 0 || n_done != n_popped) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_len(logic [tlik_pkg::CFG_IDX_W-1:0] idx,
                           logic [tlik_pkg::LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == tlik_pkg::REG_FEMUR) femur_len = v;
    else tibia_len = v;
  endtask

  initial begin
    int lens[6][2];
    lens = '{'{1600, 1600}, '{1, 1}, '{32767, 32767}, '{0, 300}, '{2500, 900},
             '{700, 32767}};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: zero offset, extremes, axes, both half-planes
    queue_target('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    queue_target('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
    queue_target('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    queue_target('{16'sh7fff, 16'sd0, 16'sd0, 16'sd0});
    queue_target('{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
    queue_target('{16'sd0, 16'sh7fff, 16'sd0, 16'sd0});
    queue_target('{16'sd0, 16'sh8000, 16'sd0, 16'sd0});
    queue_target('{-16'sd2000, 16'sd5, 16'sd0, 16'sd0});
    queue_target('{-16'sd2000, -16'sd5, 16'sd0, 16'sd0});
    queue_target('{16'sd3200, 16'sd0, 16'sd0, 16'sd0});
    queue_target('{16'sd1000, 16'sd1000, 16'sd0, 16'sd0});
    queue_target('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    queue_target('{16'sd100, -16'sd4000, 16'sd50, 16'sd50});
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      write_len(tlik_pkg::REG_FEMUR, tlik_pkg::LEN_W'(lens[p][0]));
      write_len(tlik_pkg::REG_TIBIA, tlik_pkg::LEN_W'(lens[p][1]));
      if (p == 5) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        queue_target(rand_target());
        if (p == 2 && i == 80) begin
          // sender holds off until every result so far is back
          while (pending_targets.size() > 0) @(posedge clk);
          hold_tx = 1'b1;
          while (n_done != n_popped) @(posedge clk);
          hold_tx = 1'b0;
        end
      end
      wait_drained();
    end
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("status: fail");
    $finish;
  end
endmodule
